[sv/bfa_pkg.sv]
// Shared types and constants of the bitmap first-free allocator.
// Used by the allocator top level; no dependencies of its own.

package bfa_pkg;

  localparam int IDX_W  = 13;   // entry_index width
  localparam int CNT_W  = 14;   // num_entries, free count, alloc number width
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  localparam logic [CNT_W-1:0] NUM_RESET = 14'd8192;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_TEST  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIX,
    ST_RD,
    ST_SCAN,
    ST_RESP
  } state_e;

endpackage

[sv/bfa_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.

module bfa_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/bitmap_first_free_allocator.sv]
// Top level of the bitmap first-free allocator: request FSM, word scan, free count.
// Depends on bfa_pkg and the bfa_ram bitmap memory.
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the op (allocate, free,
//   test), tdata the entry index. One response per request leaves on m_axis.
//   num_entries is written through cfg_we_i / cfg_wdata_i while the block is
//   idle; the write also reloads the free count. The bitmap itself is kept.
//   Steps: free and test go from transfer to a valid response through index
//   split with memory read, update and response load. An allocate reads one
//   bitmap word per cycle through the single read port until it finds a free
//   entry or reaches the last managed word. Range errors and bad ops go
//   straight to the response load. One request is worked on at a time; the
//   next transfer is taken the cycle after the response load.
//   Reset: the bitmap memory is cleared by a pass over all ceil(MAP_BITS/WORD_BITS)
//   words, one word a cycle; s_axis_tready_o stays low until it ends.
//   Stall: the response sits in an output register; the next request is
//   accepted and worked on meanwhile, and its result waits until the output
//   register is taken.

module bitmap_first_free_allocator
  import bfa_pkg::*;
#(
  parameter int MAP_BITS  = 8192,
  parameter int WORD_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CNT_W-1:0]      cfg_wdata_i,     // num_entries
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // [12:0] entry_index, [15:13] zero
  input  logic [OP_W-1:0]       s_axis_tuser_i,  // [1:0] op
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o   // [13:0] alloc_number, [14] bit_value,
                                                 // [16:15] status, [30:17] free_left,
                                                 // [31] zero
);

  localparam int Words  = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AddrW  = (Words > 1) ? $clog2(Words) : 1;
  localparam int OffW   = $clog2(WORD_BITS);
  localparam int DivS   = IDX_W + OffW;
  localparam int Recip  = (1 << DivS) / WORD_BITS;
  localparam int ProdW  = IDX_W + DivS;
  localparam int CapInt = (MAP_BITS < 16383) ? MAP_BITS : 16383;
  localparam logic [CNT_W-1:0] Cap       = CNT_W'(CapInt);
  localparam logic [CNT_W-1:0] FreeRst   = (NUM_RESET > Cap) ? Cap : NUM_RESET;
  localparam logic [CNT_W-1:0] WordCnt   = CNT_W'(WORD_BITS);
  localparam logic [IDX_W-1:0] WordIdx   = IDX_W'(WORD_BITS);
  localparam logic [AddrW-1:0] LastWord  = AddrW'(Words - 1);

  state_e state_q, state_d;

  logic [CNT_W-1:0]     num_q, free_q, free_d;
  logic [CNT_W-1:0]     lim;
  logic [OP_W-1:0]      op_q;
  logic [IDX_W-1:0]     idx_q;
  logic [ProdW-1:0]     prod_q;
  logic [AddrW-1:0]     word_q, clr_q, ra_q, dw_q;
  logic [OffW-1:0]      off_q;
  logic                 dv_q;
  logic [CNT_W-1:0]     base_q;
  logic [CNT_W-1:0]     res_num_q;
  logic                 res_bit_q;
  logic [STAT_W-1:0]    res_stat_q;
  logic [CNT_W-1:0]     res_free_q;
  logic                 out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic                 in_xfer, load_out;
  logic                 op_range_ok;
  logic [IDX_W-1:0]     in_idx;

  // Index split: word = idx / WORD_BITS by reciprocal, then one correction.
  logic [IDX_W-1:0]     q_est, q_mul, r_est, q_fix, r_fix;
  logic [AddrW-1:0]     fix_word;
  logic [OffW-1:0]      fix_off;

  // Memory side
  logic                 mem_we, mem_re;
  logic [AddrW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

  // Scan word evaluation
  logic [CNT_W-1:0]     rem;
  logic [WORD_BITS-1:0] in_mask, free_bits, low_bit;
  logic [OffW-1:0]      low_pos;
  logic                 scan_found, scan_last;
  logic [CNT_W-1:0]     scan_number;

  // Free/test update
  logic                 rd_bit;
  logic [WORD_BITS-1:0] rd_clear;

  assign lim     = (num_q > Cap) ? Cap : num_q;
  assign in_idx  = s_axis_tdata_i[IDX_W-1:0];
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;
  assign op_range_ok = (s_axis_tuser_i == OP_FREE || s_axis_tuser_i == OP_TEST) &&
                       ({1'b0, in_idx} < lim);

  always_comb begin
    q_est = prod_q[ProdW-1 -: IDX_W];
    q_mul = IDX_W'(q_est * WordIdx);
    r_est = idx_q - q_mul;
    if (r_est >= WordIdx) begin
      q_fix = q_est + 1'b1;
      r_fix = r_est - WordIdx;
    end else begin
      q_fix = q_est;
      r_fix = r_est;
    end
    fix_word = q_fix[AddrW-1:0];
    fix_off  = r_fix[OffW-1:0];
  end

  always_comb begin
    rem = lim - base_q;
    for (int j = 0; j < WORD_BITS; j++) begin
      in_mask[j] = (CNT_W'(j) < rem);
    end
    free_bits = ~mem_rdata & in_mask;
    low_bit   = free_bits & (~free_bits + 1'b1);
    low_pos   = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (low_bit[j]) begin
        low_pos = low_pos | OffW'(j);
      end
    end
    scan_found  = |free_bits;
    scan_last   = (rem <= WordCnt);
    scan_number = base_q + CNT_W'(low_pos) + 1'b1;
  end

  assign rd_bit   = mem_rdata[off_q];
  assign rd_clear = mem_rdata & ~(WORD_BITS'(1) << off_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == LastWord) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          if (s_axis_tuser_i == OP_ALLOC) state_d = ST_SCAN;
          else if (op_range_ok)           state_d = ST_FIX;
          else                            state_d = ST_RESP;
        end
      end
      ST_FIX:  state_d = ST_RD;
      ST_RD:   state_d = ST_RESP;
      ST_SCAN: begin
        if (dv_q && (scan_found || scan_last)) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // FSM outputs: memory control, input ready, output load, next free count
  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = word_q;
    mem_wdata       = rd_clear;
    mem_re          = 1'b0;
    mem_raddr       = ra_q;
    s_axis_tready_o = 1'b0;
    load_out        = 1'b0;
    free_d          = free_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      ST_IDLE: s_axis_tready_o = 1'b1;
      ST_FIX: begin
        mem_re    = 1'b1;
        mem_raddr = fix_word;
      end
      ST_RD: begin
        if (op_q == OP_FREE && rd_bit) begin
          mem_we = 1'b1;
          if (free_q < lim) free_d = free_q + 1'b1;
        end
      end
      ST_SCAN: begin
        mem_re = 1'b1;
        if (dv_q && scan_found) begin
          mem_we    = 1'b1;
          mem_waddr = dw_q;
          mem_wdata = mem_rdata | low_bit;
          if (free_q != '0) free_d = free_q - 1'b1;
        end
      end
      ST_RESP: load_out = !out_valid_q || m_axis_tready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      dv_q        <= 1'b0;
      num_q       <= NUM_RESET;
      free_q      <= FreeRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (in_xfer) dv_q <= 1'b0;
      else if (state_q == ST_SCAN) dv_q <= 1'b1;
      if (load_out) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
      // Register write reloads the count; the user must not let it overlap a request, the block does not check
      if (cfg_we_i) begin
        num_q  <= cfg_wdata_i;
        free_q <= (cfg_wdata_i > Cap) ? Cap : cfg_wdata_i;
      end else begin
        free_q <= free_d;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= s_axis_tuser_i;
      idx_q  <= in_idx;
      prod_q <= ProdW'(in_idx * DivS'(Recip));
      ra_q   <= '0;
      dw_q   <= '0;
      base_q <= '0;
      if (s_axis_tuser_i != OP_ALLOC && !op_range_ok) begin
        res_num_q  <= '0;
        res_bit_q  <= 1'b0;
        res_stat_q <= STAT_RANGE;
        res_free_q <= free_q;
      end
    end
    if (state_q == ST_FIX) begin
      word_q <= fix_word;
      off_q  <= fix_off;
    end
    if (state_q == ST_RD) begin
      res_num_q  <= '0;
      res_bit_q  <= rd_bit;
      res_stat_q <= STAT_OK;
      res_free_q <= free_d;
    end
    if (state_q == ST_SCAN) begin
      ra_q <= ra_q + 1'b1;
      if (dv_q) begin
        if (scan_found) begin
          res_num_q  <= scan_number;
          res_bit_q  <= 1'b0;
          res_stat_q <= STAT_OK;
          res_free_q <= free_d;
        end else if (scan_last) begin
          res_num_q  <= '0;
          res_bit_q  <= 1'b0;
          res_stat_q <= STAT_FULL;
          res_free_q <= free_q;
        end else begin
          base_q <= base_q + WordCnt;
          dw_q   <= dw_q + 1'b1;
        end
      end
    end
    if (load_out) begin
      out_data_q <= {1'b0, res_free_q, res_stat_q, res_bit_q, res_num_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  bfa_ram #(
    .Width (WORD_BITS),
    .Depth (Words)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

`ifndef SYNTH
  a_free_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= lim)
    else $error("free count above managed entry count");

  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESP))
    else $error("response appeared without a finished request");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q != ST_IDLE)
    else $error("accepted request did not start work");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[16:15] == STAT_OK || out_data_q[16:15] == STAT_FULL ||
                     out_data_q[16:15] == STAT_RANGE))
    else $error("undefined status code on output");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || state_q == ST_RD || state_q == ST_SCAN))
    else $error("bitmap written outside clear or update");
`endif

endmodule

[tb/bitmap_first_free_allocator_checker.sv]
// Response checker for the bitmap first-free allocator: tracks num_entries writes,
// predicts each response from its own bitmap copy and compares it with m_axis.
// Depends on bfa_pkg for widths and op and status codes.
`timescale 1ns / 100ps

module bitmap_first_free_allocator_checker
  import bfa_pkg::*;
#(
  parameter int MAP_BITS = 8192
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CNT_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // [12:0] entry_index, [15:13] zero
  input  logic [OP_W-1:0]       s_axis_tuser_i,   // [1:0] op
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,   // [13:0] alloc_number, [14] bit_value,
                                                  // [16:15] status, [30:17] free_left
  output logic [31:0]           mismatch_cnt_o,
  output logic [31:0]           pending_o
);

  typedef struct packed {
    logic [CNT_W-1:0]  alloc_number;
    logic              bit_value;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  free_left;
  } alloc_resp_t;

  logic [MAP_BITS-1:0] used_map;
  logic [CNT_W-1:0]    free_cnt;
  logic [CNT_W-1:0]    num_entries;
  alloc_resp_t         resp_q[$];

  initial begin
    mismatch_cnt_o = 0;
    pending_o      = 0;
  end

  function automatic int entry_limit();
    return (num_entries > MAP_BITS) ? MAP_BITS : num_entries;
  endfunction

  // Apply one request to the bitmap copy and return the response it gives.
  function automatic alloc_resp_t apply_request(input logic [OP_W-1:0]  op,
                                                input logic [IDX_W-1:0] idx);
    alloc_resp_t r;
    int          lim;
    int          k;
    logic        found;
    lim   = entry_limit();
    r     = '0;
    found = 1'b0;
    if (op == OP_ALLOC) begin
      r.status = STAT_FULL;
      for (k = 0; k < lim && !found; k++) begin
        if (!used_map[k]) begin
          used_map[k] = 1'b1;
          if (free_cnt != 0) free_cnt--;
          r.alloc_number = CNT_W'(k + 1);
          r.status       = STAT_OK;
          found          = 1'b1;
        end
      end
    end else if (op == OP_FREE || op == OP_TEST) begin
      if (idx >= lim) begin
        r.status = STAT_RANGE;
      end else begin
        r.bit_value = used_map[idx];
        if (op == OP_FREE && r.bit_value) begin
          used_map[idx] = 1'b0;
          // count never rises above the managed entry count
          if (free_cnt < lim) free_cnt++;
        end
      end
    end else begin
      r.status = STAT_RANGE;
    end
    r.free_left = free_cnt;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_resp_t want;
    alloc_resp_t got;
    if (!rst_ni) begin
      used_map    = '0;
      num_entries = NUM_RESET;
      free_cnt    = CNT_W'(entry_limit());
      resp_q.delete();
      pending_o   = 0;
    end else begin
      if (cfg_we_i) begin
        num_entries = cfg_wdata_i;
        free_cnt    = CNT_W'(entry_limit());
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.alloc_number = m_axis_tdata_i[13:0];
        got.bit_value    = m_axis_tdata_i[14];
        got.status       = m_axis_tdata_i[16:15];
        got.free_left    = m_axis_tdata_i[30:17];
        if (resp_q.size() == 0) begin
          if (mismatch_cnt_o < 10)
            $display("%0t: response with nothing outstanding: %s %0d bit %0d %s %0d free %0d",
                     $realtime, "number", got.alloc_number, got.bit_value, "status",
                     got.status, got.free_left);
          mismatch_cnt_o++;
        end else begin
          want = resp_q.pop_front();
          if (got.alloc_number !== want.alloc_number || got.bit_value !== want.bit_value ||
              got.status !== want.status || got.free_left !== want.free_left) begin
            if (mismatch_cnt_o < 10)
              $display("%0t: mismatch: number %0d/%0d bit %0d/%0d %s %0d/%0d %s %0d/%0d %s",
                       $realtime, want.alloc_number, got.alloc_number, want.bit_value,
                       got.bit_value, "status", want.status, got.status, "free",
                       want.free_left, got.free_left, "(exp/got)");
            mismatch_cnt_o++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        resp_q.push_back(apply_request(s_axis_tuser_i, s_axis_tdata_i[IDX_W-1:0]));
      pending_o = resp_q.size();
    end
  end

endmodule

[tb/bitmap_first_free_allocator_test.sv]
// Top of the bitmap first-free allocator testbench: clock, reset, request stimulus
// and num_entries phases. Depends on bfa_pkg, the allocator and its checker.
`timescale 1ns / 100ps

module bitmap_first_free_allocator_test
  import bfa_pkg::*;
();

  localparam int MAP_BITS  = 8192;
  localparam int WORD_BITS = 32;
  localparam int N_PHASES  = 8;
  localparam logic [OP_W-1:0] OP_BAD = 2'd3;

  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CNT_W-1:0]      cfg_wdata_i     = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;   // [12:0] entry_index, [15:13] zero
  logic [OP_W-1:0]       s_axis_tuser_i  = '0;   // [1:0] op
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;         // [13:0] alloc_number, [14] bit_value,
                                                 // [16:15] status, [30:17] free_left
  logic [31:0]           mismatch_cnt;
  logic [31:0]           pending_cnt;

  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;
  int   cur_limit = MAP_BITS;
  int   sent_cnt  = 0;

  bitmap_first_free_allocator #(
    .MAP_BITS  (MAP_BITS),
    .WORD_BITS (WORD_BITS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  bitmap_first_free_allocator_checker #(
    .MAP_BITS (MAP_BITS)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .mismatch_cnt_o  (mismatch_cnt),
    .pending_o       (pending_cnt)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= rx_steady || ($urandom_range(99) >= 36);
  end

  // Offer one request (random gap first unless tx_steady) and hold it until the transfer.
  task automatic send_req(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
    while (!tx_steady && $urandom_range(99) < 36) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_DATA_W-IDX_W){1'b0}}, idx};
    s_axis_tuser_i  <= op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_entries(input int value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CNT_W'(value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_limit = (value > MAP_BITS) ? MAP_BITS : value;
  endtask

  // Mostly allocates and frees near the low end, plus range-edge and full-range indexes.
  task automatic random_req();
    int              r;
    int              s;
    int              span;
    int              idx;
    logic [OP_W-1:0] op;
    r = $urandom_range(99);
    if (r < 45)      op = OP_ALLOC;
    else if (r < 72) op = OP_FREE;
    else if (r < 94) op = OP_TEST;
    else             op = OP_BAD;
    s    = $urandom_range(99);
    span = ((cur_limit < 128) ? cur_limit : 128) + 1;
    if (s < 60)                       idx = $urandom_range(span);
    else if (s < 80 && cur_limit > 0) idx = cur_limit - 2 + $urandom_range(3);
    else                              idx = $urandom_range(MAP_BITS - 1);
    send_req(op, IDX_W'(idx));
  endtask

  initial begin : stimulus
    int phase_entries[N_PHASES];
    int phase_items[N_PHASES];
    int p;
    int n;
    phase_entries = '{8192, 40, 1, 0, 16383, 300, 33, 0};
    phase_items   = '{150, 120, 40, 30, 120, 150, 80, 60};
    phase_entries[N_PHASES-1] = $urandom_range(8192, 2);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: first allocations, tests at both ends, double free, bad ops
    send_req(OP_ALLOC, 0);
    send_req(OP_ALLOC, 8191);
    send_req(OP_TEST, 0);
    send_req(OP_TEST, 8191);
    send_req(OP_FREE, 0);
    send_req(OP_FREE, 0);
    send_req(OP_TEST, 0);
    send_req(OP_ALLOC, 0);
    send_req(OP_BAD, 8191);
    send_req(OP_BAD, 0);
    send_req(OP_FREE, 8191);
    // single entry already taken: full allocate, range error, capped free count
    set_entries(1);
    send_req(OP_ALLOC, 0);
    send_req(OP_FREE, 1);
    send_req(OP_FREE, 0);
    send_req(OP_ALLOC, 0);
    send_req(OP_ALLOC, 0);
    // no managed entries at all
    set_entries(0);
    send_req(OP_ALLOC, 0);
    send_req(OP_FREE, 0);
    send_req(OP_TEST, 8191);
    // register above the map size clamps to the full map
    set_entries(16383);
    send_req(OP_TEST, 8191);
    send_req(OP_ALLOC, 0);
    send_req(OP_FREE, 1);

    for (p = 0; p < N_PHASES; p++) begin
      set_entries(phase_entries[p]);
      tx_steady = (p == 4);
      rx_steady = (p == 4);
      for (n = 0; n < phase_items[p]; n++) begin
        // hold off the sender once until the block has answered everything
        if (p == 5 && n == phase_items[p] / 2) drain_results();
        random_req();
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    drain_results();
    repeat (300) @(negedge clk_i);
    $display("Sent %0d requests: directed edge cases, then %0d random phases", sent_cnt,
             N_PHASES);
    $display("with num_entries of 0, 1, 33, 40, 300, 8192, 16383 and one random size");
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
